// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg: shared constants for the point-in-polygon ray test
// Coordinate and ray widths, the default coordinate width and the reset
// value of the ray length register.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int RAY_BITS       = 31;
  localparam int FRAC_BITS      = 16;
  localparam int RAY_UNITS      = 10000;

  // 10000.0 in unsigned Q15.16.
  localparam logic [RAY_BITS-1:0] RAY_RESET = RAY_BITS'(RAY_UNITS) << FRAC_BITS;

endpackage

// ===== rtl/pip_if.sv =====
// ----------------------------------------------------------------------------
// pip_if: valid/ready channels of the point-in-polygon ray test
// pip_vtx_if carries one polygon vertex and the query point per beat,
// pip_res_if carries the inside flag of one finished polygon.
// ----------------------------------------------------------------------------
interface pip_vtx_if #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic                         last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
    output ready
  );
endinterface

interface pip_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ===== rtl/point_in_polygon_ray_cast.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast: even-odd point-in-polygon test
// Vertices stream in on vtx_i, one per beat; the query point is taken from
// the first beat of each polygon and last_vertex closes the polygon. A
// horizontal ray of length ray_length is cast from the query point and
// every edge, including the closing one, is tested against it exactly.
// On the closing beat one result beat leaves on res_o: inside_res = 1 when
// the number of crossings is odd.
// The block takes one vertex per clock while no stalled result backs up
// the pipeline. The work runs in three registered steps: edge differences,
// products (the multipliers set the clock), and compare plus parity into
// the result register, from which inside_res is driven.
// A stalled result holds in the output register; vertices that close no
// polygon keep flowing past it until the next closing vertex reaches step 3,
// and the input stalls once step 1 is full behind that vertex.
// Reset empties the pipeline, sets ray_length to 10000.0 and makes the next
// beat the first vertex of a polygon. The user writes ray_length through
// cfg_we_i/cfg_wdata_i only while no beat is in flight; this is not enforced.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pip_pkg::RAY_BITS-1:0]  cfg_wdata_i,
  pip_vtx_if.sink                       vtx_i,
  pip_res_if.source                     res_o
);

  localparam int D  = COORD_BITS + 1;           // edge difference width
  localparam int RW = pip_pkg::RAY_BITS + 1 + D; // ray times difference
  localparam int PW = 2 * D;                     // difference times difference
  localparam int W  = (PW + 1 > RW) ? PW + 1 : RW;

  // Ray length register.
  logic [pip_pkg::RAY_BITS-1:0] ray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q <= pip_pkg::RAY_RESET;
    end else if (cfg_we_i) begin
      ray_q <= cfg_wdata_i;
    end
  end

  // Polygon state kept at the input side.
  logic                         mid_q;
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] held_x_q, held_y_q;

  // Pipeline handshake.
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_move, s2_free, s1_move, in_fire;
  logic s2_last_q;

  assign out_free = !out_valid_q || res_o.ready;
  assign s2_move  = s2_valid_q && (!s2_last_q || out_free);
  assign s2_free  = !s2_valid_q || s2_move;
  assign s1_move  = s1_valid_q && s2_free;
  assign vtx_i.ready = !s1_valid_q || s1_move;
  assign in_fire  = vtx_i.valid && vtx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (in_fire) begin
      mid_q <= !vtx_i.last_vertex;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_x_q <= vtx_i.vertex_x;
      prev_y_q <= vtx_i.vertex_y;
      if (!mid_q) begin
        first_x_q <= vtx_i.vertex_x;
        first_y_q <= vtx_i.vertex_y;
        held_x_q  <= vtx_i.query_x;
        held_y_q  <= vtx_i.query_y;
      end
    end
  end

  // Step 1: edge differences. Edge 0 runs from the new vertex to the
  // previous one, edge 1 from the first vertex to the new one.
  logic signed [D-1:0] s2x_d [2], s2y_d [2], dx_d [2], dy_d [2];
  logic signed [D-1:0] s2x_q [2], s2y_q [2], dx_q [2], dy_q [2];
  logic signed [COORD_BITS-1:0] qx, qy, ax1, ay1;
  logic s1_first_q, s1_last_q;

  always_comb begin
    qx  = mid_q ? held_x_q  : vtx_i.query_x;
    qy  = mid_q ? held_y_q  : vtx_i.query_y;
    ax1 = mid_q ? first_x_q : vtx_i.vertex_x;
    ay1 = mid_q ? first_y_q : vtx_i.vertex_y;
    s2x_d[0] = D'(prev_x_q) - D'(vtx_i.vertex_x);
    s2y_d[0] = D'(prev_y_q) - D'(vtx_i.vertex_y);
    dx_d[0]  = D'(qx) - D'(vtx_i.vertex_x);
    dy_d[0]  = D'(qy) - D'(vtx_i.vertex_y);
    s2x_d[1] = D'(vtx_i.vertex_x) - D'(ax1);
    s2y_d[1] = D'(vtx_i.vertex_y) - D'(ay1);
    dx_d[1]  = D'(qx) - D'(ax1);
    dy_d[1]  = D'(qy) - D'(ay1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (vtx_i.ready) begin
      s1_valid_q <= vtx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s2x_q      <= s2x_d;
      s2y_q      <= s2y_d;
      dx_q       <= dx_d;
      dy_q       <= dy_d;
      s1_first_q <= !mid_q;
      s1_last_q  <= vtx_i.last_vertex;
    end
  end

  // Step 2: products. den = L*s2y, sn = L*dy and both terms of tn = s2x*dy - s2y*dx.
  logic signed [RW-1:0] den_d [2], sn_d [2], den_q [2], sn_q [2];
  logic signed [PW-1:0] pa_d [2], pb_d [2], pa_q [2], pb_q [2];
  logic signed [pip_pkg::RAY_BITS:0] ray_s;
  logic s2_first_q;

  assign ray_s = $signed({1'b0, ray_q});

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      den_d[e] = RW'(ray_s) * RW'(s2y_q[e]);
      sn_d[e]  = RW'(ray_s) * RW'(dy_q[e]);
      pa_d[e]  = PW'(s2x_q[e]) * PW'(dy_q[e]);
      pb_d[e]  = PW'(s2y_q[e]) * PW'(dx_q[e]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      den_q      <= den_d;
      sn_q       <= sn_d;
      pa_q       <= pa_d;
      pb_q       <= pb_d;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // Step 3: closed-segment test on both edges and the parity update.
  logic signed [W-1:0] den_w [2], sn_w [2], tn_w [2];
  logic [1:0] hit;
  logic parity_q, parity_d;
  logic inside_q;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      den_w[e] = W'(den_q[e]);
      sn_w[e]  = W'(sn_q[e]);
      tn_w[e]  = W'(pa_q[e]) - W'(pb_q[e]);
      if (den_w[e] == '0) begin
        hit[e] = 1'b0;
      end else if (den_w[e] > 0) begin
        hit[e] = (sn_w[e] >= 0) && (sn_w[e] <= den_w[e]) &&
                 (tn_w[e] >= 0) && (tn_w[e] <= den_w[e]);
      end else begin
        hit[e] = (sn_w[e] <= 0) && (sn_w[e] >= den_w[e]) &&
                 (tn_w[e] <= 0) && (tn_w[e] >= den_w[e]);
      end
    end
    // The first vertex of a polygon has no edge to its predecessor, and the
    // closing edge counts only on the last vertex.
    parity_d = (s2_first_q ? 1'b0 : (parity_q ^ hit[0])) ^ (s2_last_q & hit[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_move) begin
        parity_q <= parity_d;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q && s2_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move && s2_last_q) begin
      inside_q <= parity_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.inside_res = inside_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for point_in_polygon_ray_cast
// A short table of hand-made polygons runs first at the reset ray length,
// then random polygons (local, grid, full-range and corner-valued shapes)
// are streamed under several ray lengths. A tracker of the even-odd crossing
// parity, updated on every accepted beat, predicts each inside flag unless a
// table row pins it; each result beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CB        = pip_pkg::COORD_BITS_DEF;
  localparam int RB        = pip_pkg::RAY_BITS;
  localparam int LIMIT     = 400000;
  localparam int N_PHASES  = 8;
  localparam int PHASE_BEATS = 200;
  localparam int N_DIR     = 21;

  localparam logic signed [CB-1:0] ONE  = 32'sd65536;
  localparam logic signed [CB-1:0] MAXC = 32'sh7fffffff;
  localparam logic signed [CB-1:0] MINC = 32'sh80000000;
  localparam logic signed [CB-1:0] RAYX = 32'sd655360000;
  localparam logic [RB-1:0]        RAY_MAX = '1;

  typedef enum int {SHAPE_LOCAL, SHAPE_GRID, SHAPE_WILD, SHAPE_CORNER} shape_e;

  typedef struct packed {
    logic signed [CB-1:0] vx;
    logic signed [CB-1:0] vy;
    logic signed [CB-1:0] qx;
    logic signed [CB-1:0] qy;
    logic                 last;
  } vertex_beat_t;

  typedef struct packed {
    vertex_beat_t beat;
    logic         has_exp;
    logic         exp_inside;
  } probe_row_t;

  // Hand-made polygons at the reset ray length of 10000.0.
  localparam probe_row_t DIR_ROWS [N_DIR] = '{
    // Square of side 2.0 around the query point; later queries are ignored.
    '{'{-ONE, -ONE, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{ ONE, -ONE, MAXC, MINC, 1'b0}, 1'b0, 1'b0},
    '{'{ ONE,  ONE, MINC, MAXC, 1'b0}, 1'b0, 1'b0},
    '{'{-ONE,  ONE, 32'sd0, 32'sd0, 1'b1}, 1'b1, 1'b1},
    // A lone vertex only makes a degenerate edge.
    '{'{5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 1'b1}, 1'b1, 1'b0},
    // Two vertices test the same segment twice.
    '{'{ONE, -ONE, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{ONE,  ONE, 32'sd0, 32'sd0, 1'b1}, 1'b1, 1'b0},
    // Query left of the square: the ray passes through both sides.
    '{'{-ONE, -ONE, -3 * ONE, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{ ONE, -ONE, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{ ONE,  ONE, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{-ONE,  ONE, 32'sd0, 32'sd0, 1'b1}, 1'b0, 1'b0},
    // Full-range square with the query sitting on its left side.
    '{'{MINC, MINC, MINC, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{MAXC, MINC, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{MAXC, MAXC, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{MINC, MAXC, 32'sd0, 32'sd0, 1'b1}, 1'b0, 1'b0},
    // Edge exactly at the end of the ray.
    '{'{RAYX, -ONE, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{RAYX,  ONE, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{RAYX + ONE, 32'sd0, 32'sd0, 32'sd0, 1'b1}, 1'b0, 1'b0},
    // Horizontal edge lying on the ray.
    '{'{ONE,     32'sd0, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{2 * ONE, 32'sd0, 32'sd0, 32'sd0, 1'b0}, 1'b0, 1'b0},
    '{'{2 * ONE, ONE,    32'sd0, 32'sd0, 1'b1}, 1'b0, 1'b0}
  };

  logic          clk;
  logic          rst_ni;
  logic          cfg_we;
  logic [RB-1:0] cfg_wdata;

  pip_vtx_if #(.COORD_BITS(CB)) vtx_bus ();
  pip_res_if                    res_bus ();

  point_in_polygon_ray_cast #(
    .COORD_BITS(CB)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .vtx_i      (vtx_bus),
    .res_o      (res_bus)
  );

  // Parity tracker state, updated on every accepted vertex beat.
  logic [RB-1:0]        trk_ray = pip_pkg::RAY_RESET;
  logic signed [CB-1:0] trk_fx = '0, trk_fy = '0, trk_px = '0, trk_py = '0;
  logic signed [CB-1:0] trk_qx = '0, trk_qy = '0;
  logic                 trk_parity = 1'b0;
  logic                 trk_open = 1'b0;

  logic       inside_q [$];
  logic [1:0] pinned_q [$];   // {has_exp, exp_inside} per directed closing beat

  int  errors = 0;
  int  results_seen = 0;
  int  beats_sent = 0;
  bit  src_idle = 1'b0;
  bit  sink_idle = 1'b0;

  // Exact closed-segment test of the ray from (qx,qy) against edge a-b.
  function automatic logic ray_hits_edge(
    input logic signed [CB-1:0] qx, qy, ax, ay, bx, by,
    input logic [RB-1:0]        ray
  );
    logic signed [127:0] len, ex, ey, ox, oy, den, sn, tn;
    len = ray;
    ex  = bx - ax;
    ey  = by - ay;
    ox  = qx - ax;
    oy  = qy - ay;
    den = len * ey;
    sn  = len * oy;
    tn  = ex * oy - ey * ox;
    if (den == 0) return 1'b0;
    if (den > 0) return sn >= 0 && sn <= den && tn >= 0 && tn <= den;
    return sn <= 0 && sn >= den && tn <= 0 && tn >= den;
  endfunction

  function automatic logic signed [CB-1:0] pick_coord(
    input shape_e shape, input logic signed [CB-1:0] centre, input int span
  );
    case (shape)
      SHAPE_LOCAL: return centre + (int'($urandom_range(0, 2 * span)) - span);
      SHAPE_GRID:  return centre + ONE * (int'($urandom_range(0, 6)) - 3);
      SHAPE_WILD:  return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return MINC;
          1: return MAXC;
          2: return '0;
          3: return -1;
          4: return 1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic send_beat(input vertex_beat_t b);
    if (src_idle && $urandom_range(0, 2) == 0) begin
      vtx_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    vtx_bus.valid       <= 1'b1;
    vtx_bus.vertex_x    <= b.vx;
    vtx_bus.vertex_y    <= b.vy;
    vtx_bus.query_x     <= b.qx;
    vtx_bus.query_y     <= b.qy;
    vtx_bus.last_vertex <= b.last;
    do @(posedge clk); while (!vtx_bus.ready);
    beats_sent++;
  endtask

  // Drops valid, waits for every pending flag plus the pipeline depth.
  task automatic drain_results();
    vtx_bus.valid <= 1'b0;
    @(posedge clk);
    while (inside_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d flags still pending", $time, inside_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: ready comes in random stretches with short stalls while sink_idle is set.
  initial begin
    res_bus.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk);
    forever begin
      if (sink_idle && $urandom_range(0, 2) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  // Check result beats first, then fold in the configuration and vertex beats.
  always @(posedge clk) begin : track
    logic       want;
    logic [1:0] pin;
    if (res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (inside_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual inside_res=%0b",
                 $time, res_bus.inside_res);
        errors++;
      end else begin
        want = inside_q.pop_front();
        if (res_bus.inside_res !== want) begin
          $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                   $time, want, res_bus.inside_res);
          errors++;
        end
      end
    end
    if (cfg_we) trk_ray = cfg_wdata;
    if (vtx_bus.valid && vtx_bus.ready) begin
      if (!trk_open) begin
        trk_qx     = vtx_bus.query_x;
        trk_qy     = vtx_bus.query_y;
        trk_fx     = vtx_bus.vertex_x;
        trk_fy     = vtx_bus.vertex_y;
        trk_parity = 1'b0;
      end else if (ray_hits_edge(trk_qx, trk_qy, vtx_bus.vertex_x, vtx_bus.vertex_y,
                                 trk_px, trk_py, trk_ray)) begin
        trk_parity = ~trk_parity;
      end
      trk_px = vtx_bus.vertex_x;
      trk_py = vtx_bus.vertex_y;
      if (!vtx_bus.last_vertex) begin
        trk_open = 1'b1;
      end else begin
        if (ray_hits_edge(trk_qx, trk_qy, trk_fx, trk_fy, vtx_bus.vertex_x,
                          vtx_bus.vertex_y, trk_ray)) begin
          trk_parity = ~trk_parity;
        end
        trk_open = 1'b0;
        want = trk_parity;
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin[1]) want = pin[0];
        end
        inside_q.insert(inside_q.size(), want);
      end
    end
  end

  initial begin : stimulus
    vertex_beat_t         b;
    shape_e               shape;
    logic signed [CB-1:0] cx, cy;
    int                   n, span, phase_beats;

    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    vtx_bus.valid       <= 1'b0;
    vtx_bus.vertex_x    <= '0;
    vtx_bus.vertex_y    <= '0;
    vtx_bus.query_x     <= '0;
    vtx_bus.query_y     <= '0;
    vtx_bus.last_vertex <= 1'b0;
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk);

    src_idle  = 1'b1;
    sink_idle = 1'b1;
    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].beat.last)
        pinned_q.insert(pinned_q.size(), {DIR_ROWS[i].has_exp, DIR_ROWS[i].exp_inside});
      send_beat(DIR_ROWS[i].beat);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      cfg_we <= 1'b1;
      case (p)
        0: cfg_wdata <= RB'(1);
        1: cfg_wdata <= RAY_MAX;
        2: cfg_wdata <= '0;
        3: cfg_wdata <= pip_pkg::RAY_RESET;
        4: cfg_wdata <= RB'($urandom_range(1, 64));
        default: cfg_wdata <= RB'($urandom);
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;

      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        // The final phase runs with the source always valid and the sink always ready.
        src_idle  = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        sink_idle = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 19))
          0:       n = 1;
          1:       n = 2;
          2:       n = $urandom_range(9, 24);
          default: n = $urandom_range(3, 8);
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: shape = SHAPE_LOCAL;
          5, 6:          shape = SHAPE_GRID;
          7, 8:          shape = SHAPE_WILD;
          default:       shape = SHAPE_CORNER;
        endcase
        case ($urandom_range(0, 2))
          0:       span = 8;
          1:       span = 1 << 18;
          default: span = 1 << 24;
        endcase
        if (shape == SHAPE_GRID) begin
          cx = ONE * (int'($urandom_range(0, 20)) - 10);
          cy = ONE * (int'($urandom_range(0, 20)) - 10);
        end else begin
          cx = int'($urandom_range(0, 1 << 29)) - (1 << 28);
          cy = int'($urandom_range(0, 1 << 29)) - (1 << 28);
        end
        for (int v = 0; v < n; v++) begin
          b.vx = pick_coord(shape, cx, span);
          b.vy = pick_coord(shape, cy, span);
          if (v == 0) begin
            b.qx = pick_coord(shape, cx, span);
            b.qy = pick_coord(shape, cy, span);
          end else begin
            b.qx = $urandom;
            b.qy = $urandom;
          end
          b.last = (v == n - 1);
          send_beat(b);
          phase_beats++;
        end
      end
    end

    vtx_bus.valid <= 1'b0;
    @(posedge clk);
    while (inside_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Streamed %0d vertex beats and checked %0d inside flags.",
             beats_sent, results_seen);
    $display("Ray lengths: reset, one, full scale, zero and %0d random values.",
             N_PHASES - 4);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
